// File: sv/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Types, constants and small helpers shared by the npt time range parser.
// ----------------------------------------------------------------------------
`default_nettype none

package npt_pkg;

  // fraction digits kept, and the fixed width of the fraction fields
  localparam int FRAC_DIGITS  = 6;
  localparam int FRAC_W       = 20;
  localparam int CNT_W        = 3;

  // whole seconds limit and the saturating digit group one bit wider
  localparam int SECONDS_BITS = 31;
  localparam int FG_W         = SECONDS_BITS + 1;
  localparam logic [FG_W-1:0] SEC_LIMIT = {1'b0, {SECONDS_BITS{1'b1}}};
  localparam logic [FG_W-1:0] SEC_SAT   = {1'b1, {SECONDS_BITS{1'b0}}};

  // time scaling
  localparam int MULT_W = 12;
  localparam logic [MULT_W-1:0] SECS_PER_MIN  = MULT_W'(60);
  localparam logic [MULT_W-1:0] SECS_PER_HOUR = MULT_W'(3600);
  localparam logic [MULT_W-1:0] SECS_UNIT     = MULT_W'(1);
  localparam int PROD_W = FG_W + MULT_W + 1;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // stream widths
  localparam int IN_W  = 8;
  localparam int OUT_W = 112;

  typedef enum logic [3:0] {
    PH_BEGIN,
    PH_PREFIX,
    PH_TSTART,
    PH_DIGITS,
    PH_COLON1,
    PH_E2,
    PH_AFTER_E,
    PH_COLON2,
    PH_F2,
    PH_AFTER_F,
    PH_FRAC
  } phase_t;

  // one time value being collected
  typedef struct packed {
    logic [FG_W-1:0]   fg;
    logic [1:0]        digits;
    logic [1:0]        colons;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [FRAC_W-1:0] acc;
    logic [CNT_W-1:0]  cnt;
  } time_t;

  // parser state captured on the last character
  typedef struct packed {
    time_t                   tm;
    logic                    fin_phase;
    logic                    start_pres;
    logic                    in_stop;
    logic [SECONDS_BITS-1:0] saved_secs;
    logic [FRAC_W-1:0]       saved_frac;
  } snap_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_N;
      2'd1:    c = CH_P;
      2'd2:    c = CH_T;
      default: c = CH_COLON;
    endcase
    return c;
  endfunction

  // scale that pads a fraction of cnt digits out to FRAC_DIGITS digits
  function automatic logic [FRAC_W-1:0] pad_scale(input logic [CNT_W-1:0] cnt);
    logic [FRAC_W-1:0] r;
    r = FRAC_W'(1);
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (CNT_W'(i) >= cnt) begin
        r = FRAC_W'(r * FRAC_W'(10));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/npt_finish.sv
// ----------------------------------------------------------------------------
// npt_finish
// Closes one time value: whole seconds with range checks, padded fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_finish (
  input  npt_pkg::time_t                    tm,
  output logic                              ok,
  output logic [npt_pkg::SECONDS_BITS-1:0]  secs,
  output logic [npt_pkg::FRAC_W-1:0]        frac
);
  import npt_pkg::*;

  logic [MULT_W-1:0]   scale;
  logic [MULT_W-1:0]   low;
  logic [PROD_W-1:0]   total;
  logic [2*FRAC_W-1:0] frac_wide;
  logic                mmss_bad;

  always_comb begin
    case (tm.colons)
      2'd0: begin
        scale = SECS_UNIT;
        low   = '0;
      end
      2'd1: begin
        scale = SECS_PER_MIN;
        low   = MULT_W'(tm.minute);
      end
      default: begin
        scale = SECS_PER_HOUR;
        low   = MULT_W'(MULT_W'(tm.minute) * SECS_PER_MIN) + MULT_W'(tm.second);
      end
    endcase
  end

  assign total     = PROD_W'(tm.fg) * PROD_W'(scale) + PROD_W'(low);
  // mm:ss form needs exactly two leading digits below sixty
  assign mmss_bad  = (tm.colons == 2'd1) &&
                     ((tm.digits != 2'd2) || (tm.fg >= FG_W'(60)));
  assign ok        = !mmss_bad && (total <= PROD_W'(SEC_LIMIT));
  assign secs      = total[SECONDS_BITS-1:0];
  assign frac_wide = tm.acc * pad_scale(tm.cnt);
  assign frac      = frac_wide[FRAC_W-1:0];

endmodule

`default_nettype wire

// File: sv/npt_parser.sv
// ----------------------------------------------------------------------------
// npt_parser
// Per-character grammar state and the capture register for finished strings.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  output logic                in_take,
  output logic                snap_valid,
  output npt_pkg::snap_t      snap,
  input  logic                snap_ready
);
  import npt_pkg::*;

  phase_t                  phase_r, phase_nxt, ph_eff;
  logic [1:0]              pidx_r, pidx_nxt;
  time_t                   tm_r, tm_nxt;
  logic [SECONDS_BITS-1:0] saved_secs_r, saved_secs_nxt;
  logic [FRAC_W-1:0]       saved_frac_r, saved_frac_nxt;
  logic                    err_r, err_nxt;
  logic                    spres_r, spres_nxt;
  logic                    in_stop_r, in_stop_nxt;
  logic                    snap_valid_r;
  snap_t                   snap_r;

  logic                    step;
  logic                    is_dig;
  logic [3:0]              dval;
  logic                    take_prefix;
  logic                    tail_en, tail_dot, tail_comma, tail_bad;
  logic [9:0]              two_v;
  logic [FG_W+3:0]         fg_mac;
  logic                    fin_ok;
  logic [SECONDS_BITS-1:0] fin_secs;
  logic [FRAC_W-1:0]       fin_frac;

  // a last character waits until the capture register is free
  assign in_take = in_valid && (!in_last || !snap_valid_r || snap_ready);
  assign step    = in_take;

  assign is_dig      = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign dval        = in_char[3:0];
  assign take_prefix = (phase_r == PH_BEGIN) && (in_char == CH_N) && !in_last;
  assign ph_eff      = (phase_r == PH_BEGIN) ? PH_TSTART : phase_r;

  assign two_v  = 10'((ph_eff == PH_E2) ? tm_r.minute : tm_r.second) * 10'd10 + 10'(dval);
  assign fg_mac = (FG_W+4)'({tm_r.fg, 3'b000}) + (FG_W+4)'({tm_r.fg, 1'b0})
                + (FG_W+4)'(dval);

  // phases that may close a time on a dot or comma
  assign tail_en = !take_prefix &&
                   ((ph_eff == PH_DIGITS && !is_dig && in_char != CH_COLON) ||
                    (ph_eff == PH_AFTER_E && in_char != CH_COLON) ||
                    (ph_eff == PH_AFTER_F) ||
                    (ph_eff == PH_FRAC && in_char == CH_COMMA));
  assign tail_dot   = tail_en && (in_char == CH_DOT) && (ph_eff != PH_FRAC);
  assign tail_comma = tail_en && !tail_dot && (in_char == CH_COMMA) && !in_stop_r;
  assign tail_bad   = tail_en && !tail_dot && !tail_comma;

  npt_finish u_start_fin (
    .tm   (tm_r),
    .ok   (fin_ok),
    .secs (fin_secs),
    .frac (fin_frac)
  );

  // next phase
  always_comb begin
    phase_nxt = ph_eff;
    if (err_r) begin
      phase_nxt = phase_r;
    end else if (take_prefix) begin
      phase_nxt = PH_PREFIX;
    end else begin
      case (ph_eff)
        PH_PREFIX: begin
          if (in_char == prefix_char(pidx_r) && pidx_r == 2'd3) phase_nxt = PH_TSTART;
        end
        PH_TSTART: begin
          if (is_dig) phase_nxt = PH_DIGITS;
        end
        PH_DIGITS: begin
          if (!is_dig && in_char == CH_COLON) phase_nxt = PH_COLON1;
        end
        PH_COLON1: begin
          if (is_dig) phase_nxt = PH_E2;
        end
        PH_COLON2: begin
          if (is_dig) phase_nxt = PH_F2;
        end
        PH_E2: begin
          if (is_dig && two_v < 10'd60) phase_nxt = PH_AFTER_E;
        end
        PH_F2: begin
          if (is_dig && two_v < 10'd60) phase_nxt = PH_AFTER_F;
        end
        PH_AFTER_E: begin
          if (in_char == CH_COLON) phase_nxt = PH_COLON2;
        end
        default: ;
      endcase
      if (tail_dot) phase_nxt = PH_FRAC;
      if (tail_comma && fin_ok) phase_nxt = PH_TSTART;
    end
  end

  // datapath and flags
  always_comb begin
    pidx_nxt       = pidx_r;
    tm_nxt         = tm_r;
    saved_secs_nxt = saved_secs_r;
    saved_frac_nxt = saved_frac_r;
    err_nxt        = err_r;
    spres_nxt      = spres_r;
    in_stop_nxt    = in_stop_r;
    if (!err_r) begin
      if (take_prefix) begin
        pidx_nxt = 2'd1;
      end else begin
        case (ph_eff)
          PH_PREFIX: begin
            if (in_char == prefix_char(pidx_r)) pidx_nxt = pidx_r + 2'd1;
            else err_nxt = 1'b1;
          end
          PH_TSTART: begin
            if (is_dig) begin
              tm_nxt        = '0;
              tm_nxt.fg     = FG_W'(dval);
              tm_nxt.digits = 2'd1;
            end else if (in_char == CH_COMMA && !in_stop_r) begin
              spres_nxt   = 1'b0;
              in_stop_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_dig) begin
              // digit group saturates just past the seconds limit
              if (fg_mac > (FG_W+4)'(SEC_LIMIT)) tm_nxt.fg = SEC_SAT;
              else tm_nxt.fg = fg_mac[FG_W-1:0];
              if (tm_r.digits != 2'd3) tm_nxt.digits = tm_r.digits + 2'd1;
            end else if (in_char == CH_COLON) begin
              tm_nxt.colons = 2'd1;
            end
          end
          PH_COLON1: begin
            if (is_dig) tm_nxt.minute = 6'(dval);
            else err_nxt = 1'b1;
          end
          PH_COLON2: begin
            if (is_dig) tm_nxt.second = 6'(dval);
            else err_nxt = 1'b1;
          end
          PH_E2: begin
            if (!is_dig || two_v >= 10'd60) err_nxt = 1'b1;
            else tm_nxt.minute = two_v[5:0];
          end
          PH_F2: begin
            if (!is_dig || two_v >= 10'd60) err_nxt = 1'b1;
            else tm_nxt.second = two_v[5:0];
          end
          PH_AFTER_E: begin
            if (in_char == CH_COLON) tm_nxt.colons = 2'd2;
          end
          PH_FRAC: begin
            if (is_dig) begin
              // digits past the kept precision are dropped
              if (tm_r.cnt < CNT_W'(FRAC_DIGITS)) begin
                tm_nxt.acc = FRAC_W'(tm_r.acc * FRAC_W'(10)) + FRAC_W'(dval);
                tm_nxt.cnt = tm_r.cnt + CNT_W'(1);
              end
            end else if (in_char != CH_COMMA) begin
              err_nxt = 1'b1;
            end
          end
          default: ;
        endcase
        if (tail_dot) begin
          tm_nxt.acc = '0;
          tm_nxt.cnt = '0;
        end
        if (tail_comma) begin
          if (fin_ok) begin
            saved_secs_nxt = fin_secs;
            saved_frac_nxt = fin_frac;
            spres_nxt      = 1'b1;
            in_stop_nxt    = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        if (tail_bad) err_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BEGIN;
      pidx_r       <= '0;
      tm_r         <= '0;
      saved_secs_r <= '0;
      saved_frac_r <= '0;
      err_r        <= 1'b0;
      spres_r      <= 1'b0;
      in_stop_r    <= 1'b0;
    end else if (step) begin
      if (in_last) begin
        // string done, start over for the next one
        phase_r      <= PH_BEGIN;
        pidx_r       <= '0;
        tm_r         <= '0;
        saved_secs_r <= '0;
        saved_frac_r <= '0;
        err_r        <= 1'b0;
        spres_r      <= 1'b0;
        in_stop_r    <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        pidx_r       <= pidx_nxt;
        tm_r         <= tm_nxt;
        saved_secs_r <= saved_secs_nxt;
        saved_frac_r <= saved_frac_nxt;
        err_r        <= err_nxt;
        spres_r      <= spres_nxt;
        in_stop_r    <= in_stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (step && in_last) begin
      snap_valid_r <= 1'b1;
    end else if (snap_ready) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      snap_r.tm         <= tm_nxt;
      snap_r.fin_phase  <= !err_nxt && (phase_nxt inside
                           {PH_DIGITS, PH_AFTER_E, PH_AFTER_F, PH_FRAC});
      snap_r.start_pres <= spres_nxt;
      snap_r.in_stop    <= in_stop_nxt;
      snap_r.saved_secs <= saved_secs_nxt;
      snap_r.saved_frac <= saved_frac_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

// File: sv/npt_time_range_parser_core.sv
// ----------------------------------------------------------------------------
// npt_time_range_parser_core
// Streaming parser for an npt time range, one character per beat.
// ----------------------------------------------------------------------------
// throughput: one character per cycle, sustained while out_tready holds
// path: the last character passes the input register, the capture register
//   and the result register in that order, and the result then sits on out_tdata
// a result beat stalls only a later last character, never the ones before it
// reset: synchronous active-low rst_n empties all stages and restarts parsing
`default_nettype none

module npt_time_range_parser_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [npt_pkg::IN_W-1:0]  in_tdata,   // [7:0] character
  input  logic                      in_tlast,   // last_char
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [npt_pkg::OUT_W-1:0] out_tdata   // [0] valid_res, [1] has_start,
                                                // [32:2] start_seconds,
                                                // [52:33] start_micros, [53] has_stop,
                                                // [84:54] stop_seconds,
                                                // [104:85] stop_micros, [111:105] zero
);
  import npt_pkg::*;

  logic                    in_valid_r;
  logic [7:0]              in_char_r;
  logic                    in_last_r;
  logic                    in_take;
  logic                    snap_valid;
  snap_t                   snap;
  logic                    out_free;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;
  logic [OUT_W-1:0]        res_data;

  logic                    fin_ok;
  logic [SECONDS_BITS-1:0] fin_secs;
  logic [FRAC_W-1:0]       fin_frac;
  logic                    res_valid;
  logic                    res_has_start, res_has_stop;
  logic [SECONDS_BITS-1:0] res_start_secs, res_stop_secs;
  logic [FRAC_W-1:0]       res_start_frac, res_stop_frac;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
  end

  npt_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid_r),
    .in_char    (in_char_r),
    .in_last    (in_last_r),
    .in_take    (in_take),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (out_free)
  );

  npt_finish u_final_fin (
    .tm   (snap.tm),
    .ok   (fin_ok),
    .secs (fin_secs),
    .frac (fin_frac)
  );

  // the time just closed is the stop time after a comma, else the lone time
  always_comb begin
    res_valid      = snap.fin_phase && fin_ok;
    res_has_start  = 1'b0;
    res_start_secs = '0;
    res_start_frac = '0;
    res_has_stop   = 1'b0;
    res_stop_secs  = '0;
    res_stop_frac  = '0;
    if (res_valid) begin
      if (snap.in_stop) begin
        res_has_start = snap.start_pres;
        if (snap.start_pres) begin
          res_start_secs = snap.saved_secs;
          res_start_frac = snap.saved_frac;
        end
        res_has_stop  = 1'b1;
        res_stop_secs = fin_secs;
        res_stop_frac = fin_frac;
      end else begin
        res_has_start  = 1'b1;
        res_start_secs = fin_secs;
        res_start_frac = fin_frac;
      end
    end
    res_data = OUT_W'({res_stop_frac, res_stop_secs, res_has_stop,
                       res_start_frac, res_start_secs, res_has_start, res_valid});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: sv/npt_checker.sv
// ----------------------------------------------------------------------------
// npt_checker
// Port-level checks on the result stream of the npt time range parser.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [npt_pkg::OUT_W-1:0] out_tdata
);
  import npt_pkg::*;

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // a rejected string reports nothing else
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_W-1:1] == '0)
    else $error("invalid result carries data");

  // an accepted string has a start or a stop, fractions in range, zero padding
  a_valid_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      (out_tdata[1] || out_tdata[53]) &&
      out_tdata[52:33] < 20'd1000000 && out_tdata[104:85] < 20'd1000000 &&
      out_tdata[OUT_W-1:105] == '0)
    else $error("malformed valid result");

endmodule

bind npt_time_range_parser_core npt_checker u_npt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
